@@ src/sac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants of the sensor alarm classifier with blinker.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TIMER_WIDTH  = 16;

  localparam int TH_WIDTH     = 16;
  localparam int TH_WORD      = 4 * TH_WIDTH;
  localparam int HALF_WIDTH   = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  // compare widths wide enough for both operands
  localparam int CMP_W = (SAMPLE_WIDTH > TH_WIDTH) ? SAMPLE_WIDTH : TH_WIDTH;
  localparam int HP_W  = (TIMER_WIDTH > HALF_WIDTH) ? TIMER_WIDTH : HALF_WIDTH;

  localparam logic [HALF_WIDTH-1:0] WARN_RESET = HALF_WIDTH'(500);
  localparam logic [HALF_WIDTH-1:0] CRIT_RESET = HALF_WIDTH'(125);

  // alert flag bit positions
  localparam int FLAG_TEMP  = 0;
  localparam int FLAG_PH    = 1;
  localparam int FLAG_TURB  = 2;
  localparam int FLAG_FAULT = 3;

  typedef enum logic [1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_WARNING  = 2'd1,
    LVL_CRITICAL = 2'd2
  } level_t;

  typedef enum logic {
    CMD_READING = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_TH   = 3'd0,
    CFG_PH_TH     = 3'd1,
    CFG_TURB_TH   = 3'd2,
    CFG_WARN_HALF = 3'd3,
    CFG_CRIT_HALF = 3'd4,
    CFG_RELAY_LVL = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [TH_WORD-1:0]    temp_th;
    logic [TH_WORD-1:0]    ph_th;
    logic [TH_WORD-1:0]    turb_th;
    logic [HALF_WIDTH-1:0] warn_half;
    logic [HALF_WIDTH-1:0] crit_half;
    logic                  relay_active_level;
  } cfg_t;

endpackage

@@ src/sac_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac channel interfaces
// Item, result and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sac_item_if;
  import sac_pkg::*;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic signed [SAMPLE_WIDTH-1:0] temp_sample;
  logic signed [SAMPLE_WIDTH-1:0] ph_sample;
  logic signed [SAMPLE_WIDTH-1:0] turb_sample;
  logic                           temp_nan;
  logic                           ph_nan;
  logic                           turb_nan;
  logic                           temp_ok;
  logic                           ph_ok;
  logic                           turb_ok;

  modport source (
    output valid, cmd, temp_sample, ph_sample, turb_sample,
           temp_nan, ph_nan, turb_nan, temp_ok, ph_ok, turb_ok,
    input  ready
  );
  modport sink (
    input  valid, cmd, temp_sample, ph_sample, turb_sample,
           temp_nan, ph_nan, turb_nan, temp_ok, ph_ok, turb_ok,
    output ready
  );
endinterface

interface sac_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] alert_level;
  logic [3:0] alert_flags;
  logic       relay_on;
  logic       relay_pin;

  modport source (
    output valid, alert_level, alert_flags, relay_on, relay_pin,
    input  ready
  );
  modport sink (
    input  valid, alert_level, alert_flags, relay_on, relay_pin,
    output ready
  );
endinterface

interface sac_cfg_if;
  import sac_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/sac_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_cfg_regs
// Configuration register bank; always ready, one write per transfer.
// ----------------------------------------------------------------------------
module sac_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  sac_cfg_if.sink       cfg,
  output sac_pkg::cfg_t regs
);
  import sac_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.temp_th            <= '0;
      regs.ph_th              <= '0;
      regs.turb_th            <= '0;
      regs.warn_half          <= WARN_RESET;
      regs.crit_half          <= CRIT_RESET;
      regs.relay_active_level <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        CFG_TEMP_TH:   regs.temp_th   <= cfg.data[TH_WORD-1:0];
        CFG_PH_TH:     regs.ph_th     <= cfg.data[TH_WORD-1:0];
        CFG_TURB_TH:   regs.turb_th   <= cfg.data[TH_WORD-1:0];
        CFG_WARN_HALF: regs.warn_half <= cfg.data[HALF_WIDTH-1:0];
        CFG_CRIT_HALF: regs.crit_half <= cfg.data[HALF_WIDTH-1:0];
        CFG_RELAY_LVL: regs.relay_active_level <= cfg.data[0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

@@ src/sac_grade.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_grade
// Classifies one sample against its packed four-threshold word.
// ----------------------------------------------------------------------------
module sac_grade (
  input  logic signed [sac_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                    nan,
  input  logic [sac_pkg::TH_WORD-1:0]             th,
  output sac_pkg::level_t                         grade
);
  import sac_pkg::*;

  logic signed [CMP_W-1:0] v, cl, wl, wh, ch;

  assign v  = CMP_W'(sample);
  assign cl = CMP_W'($signed(th[0*TH_WIDTH +: TH_WIDTH]));
  assign wl = CMP_W'($signed(th[1*TH_WIDTH +: TH_WIDTH]));
  assign wh = CMP_W'($signed(th[2*TH_WIDTH +: TH_WIDTH]));
  assign ch = CMP_W'($signed(th[3*TH_WIDTH +: TH_WIDTH]));

  // critical test wins over warning, NaN is always normal
  always_comb begin
    if (nan) begin
      grade = LVL_NORMAL;
    end else if (v <= cl || v >= ch) begin
      grade = LVL_CRITICAL;
    end else if (v < wl || v > wh) begin
      grade = LVL_WARNING;
    end else begin
      grade = LVL_NORMAL;
    end
  end

endmodule

@@ src/sensor_alarm_classifier_blinker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_alarm_classifier_blinker_core
// Sensor alarm classifier with a blinking relay driver.
//
// Channels: "item" carries readings (cmd 0) and millisecond ticks (cmd 1);
// "result" returns exactly one result per item, in order; "cfg" writes the
// threshold, half-period and relay polarity registers (always ready, write
// only while no item is in flight).
// An item is captured in the input register, then in the result
// register, where it becomes a valid result. Throughput: one item per
// cycle while result.ready is high, set by the combinational grade/timer
// update between the two registers. Stall: when result.ready is low the
// result register holds; the input register may still take one more item,
// then item.ready drops until the result is taken.
// Reset (rst, synchronous): both pipeline stages empty, level normal,
// relay off, blink timer 0, registers at their reset values.
// ----------------------------------------------------------------------------
module sensor_alarm_classifier_blinker_core (
  input  logic          clk,
  input  logic          rst,
  sac_item_if.sink      item,
  sac_result_if.source  result,
  sac_cfg_if.sink       cfg
);
  import sac_pkg::*;

  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

  cfg_t regs;

  sac_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // ---- input register ----
  logic                           s1_valid;
  logic                           s1_cmd;
  logic signed [SAMPLE_WIDTH-1:0] s1_temp, s1_ph, s1_turb;
  logic                           s1_temp_nan, s1_ph_nan, s1_turb_nan;
  logic                           s1_fault;
  logic                           s1_adv;

  // stage 1 moves on when the result register is free or being drained
  assign s1_adv     = !result.valid || result.ready;
  assign item.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_cmd      <= item.cmd;
      s1_temp     <= item.temp_sample;
      s1_ph       <= item.ph_sample;
      s1_turb     <= item.turb_sample;
      s1_temp_nan <= item.temp_nan;
      s1_ph_nan   <= item.ph_nan;
      s1_turb_nan <= item.turb_nan;
      s1_fault    <= !(item.temp_ok && item.ph_ok && item.turb_ok);
    end
  end

  // ---- classification ----
  level_t g_temp, g_ph, g_turb;

  sac_grade u_grade_temp (
    .sample (s1_temp), .nan (s1_temp_nan), .th (regs.temp_th), .grade (g_temp)
  );
  sac_grade u_grade_ph (
    .sample (s1_ph), .nan (s1_ph_nan), .th (regs.ph_th), .grade (g_ph)
  );
  sac_grade u_grade_turb (
    .sample (s1_turb), .nan (s1_turb_nan), .th (regs.turb_th), .grade (g_turb)
  );

  // ---- alarm state ----
  level_t                 level, level_next;
  logic                   relay_state, relay_state_next;
  logic [TIMER_WIDTH-1:0] edge_timer, edge_timer_next;
  logic [3:0]             flags_next;

  level_t                 lvl_max;
  logic [TIMER_WIDTH-1:0] t_inc;
  logic [HALF_WIDTH-1:0]  half;

  always_comb begin
    lvl_max = g_temp;
    if (g_ph > lvl_max) lvl_max = g_ph;
    if (g_turb > lvl_max) lvl_max = g_turb;

    t_inc = (edge_timer < TMAX) ? edge_timer + TIMER_WIDTH'(1) : edge_timer;
    half  = (level == LVL_CRITICAL) ? regs.crit_half : regs.warn_half;

    level_next       = level;
    relay_state_next = relay_state;
    edge_timer_next  = edge_timer;
    flags_next       = '0;

    case (cmd_t'(s1_cmd))
      CMD_READING: begin
        flags_next[FLAG_TEMP]  = (g_temp != LVL_NORMAL);
        flags_next[FLAG_PH]    = (g_ph   != LVL_NORMAL);
        flags_next[FLAG_TURB]  = (g_turb != LVL_NORMAL);
        flags_next[FLAG_FAULT] = s1_fault;
        // a level change restarts the blink from off
        if (lvl_max != level) begin
          level_next       = lvl_max;
          edge_timer_next  = '0;
          relay_state_next = 1'b0;
        end
      end
      CMD_TICK: begin
        edge_timer_next = t_inc;
        if (level == LVL_NORMAL) begin
          relay_state_next = 1'b0;
        end else if (HP_W'(t_inc) >= HP_W'(half)) begin
          edge_timer_next  = '0;
          relay_state_next = !relay_state;
        end
      end
      default: ;
    endcase
  end

  // ---- state and result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= LVL_NORMAL;
      relay_state  <= 1'b0;
      edge_timer   <= '0;
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= s1_valid;
      if (s1_valid) begin
        level       <= level_next;
        relay_state <= relay_state_next;
        edge_timer  <= edge_timer_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      result.alert_level <= level_next;
      result.alert_flags <= flags_next;
      result.relay_on    <= relay_state_next;
      result.relay_pin   <= relay_state_next ? regs.relay_active_level
                                             : !regs.relay_active_level;
    end
  end

endmodule
